>>> design/iq_sample_pingpong_framer_top_macros.svh
// ----------------------------------------------------------------------------
// iq_sample_pingpong_framer_top_macros.svh
// Assertion macros used by the framer sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef IQ_SAMPLE_PINGPONG_FRAMER_TOP_MACROS_SVH
`define IQ_SAMPLE_PINGPONG_FRAMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define IPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ipf assertion failed");
// checked on every edge, reset included
`define IPF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ipf assertion failed");
`else
`define IPF_ASSERT(lbl, prop)
`define IPF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> design/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg
// Types, constants and the tag coder of the I/Q ping-pong framer.
// ----------------------------------------------------------------------------
package ipf_pkg;

    // input request
    typedef struct packed {
        logic        op;
        logic [11:0] i_sample;
        logic [11:0] q_sample;
        logic [7:0]  rx_byte;
    } t_in_req;

    // output request
    typedef struct packed {
        logic        kind;
        logic        status;
        logic [15:0] i_code;
        logic [15:0] q_code;
        logic        last;
    } t_out_req;

    // output control from the sequencer
    typedef struct packed {
        logic load;
        logic kind;
        logic status;
        logic last;
        logic from_mem;
    } t_out_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEND_REC,
        ST_SEND_STAT,
        ST_DUMP
    } t_state;

    localparam logic        OP_TICK      = 1'b0;
    localparam logic        OP_CMD       = 1'b1;
    localparam logic        KIND_STATUS  = 1'b0;
    localparam logic        KIND_RECORD  = 1'b1;
    localparam logic [15:0] TAG_I        = 16'h0040;
    localparam logic [15:0] TAG_Q        = 16'h80C0;
    localparam logic [7:0]  CMD_QUERY    = 8'h10;
    localparam logic [7:0]  CMD_CONT     = 8'h20;
    localparam logic        STATUS_READY = 1'b1;
    localparam logic [7:0]  DEVICE_ID_RST = 8'd3;

    // 6 data bits per byte, tag bits on top of each byte
    function automatic logic [15:0] tag_code(input logic [11:0] v, input logic [15:0] tag);
        tag_code = tag | {2'b00, v[11:6], 8'h00} | {10'h000, v[5:0]};
    endfunction

endpackage

>>> design/iq_sample_pingpong_framer_top.sv
// ----------------------------------------------------------------------------
// iq_sample_pingpong_framer_top
// I/Q sample framer: tags samples into 16-bit codes, buffers them in two
// ping-pong banks and dumps a ready bank on a query byte.
//
//   channel  dir  handshake                 payload
//   in       in   i_in_valid / o_in_stall   i_in_data   (ipf_pkg::t_in_req)
//   out      out  o_out_valid / i_out_stall o_out_data  (ipf_pkg::t_out_req)
//   cfg      in   i_cfg_we                  i_cfg_wdata (device id)
//
// One request at a time: a sample tick or mode byte is decoded and returns to
// idle, a continuous record or status is sent after decode, and a bank dump
// follows its status, one entry per unstalled cycle via the single bank port.
// Output stalls hold the sequencer in place; input stall is high outside idle.
// Synchronous active-low reset clears control state; bank contents are not
// cleared, and entries are only read after being written.
// ----------------------------------------------------------------------------
module iq_sample_pingpong_framer_top #(
    parameter int BANK_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ipf_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ipf_pkg::t_out_req o_out_data,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);
    import ipf_pkg::*;

    localparam int ADDR_W = $clog2(BANK_DEPTH) + 1;

    logic [7:0]  r_device_id;
    logic        r_out_valid;
    t_out_req    r_out;
    logic        out_free;
    t_out_ctl    ctl;
    t_out_req    fmt_req;
    logic [23:0] live_sample, mem_rdata, fmt_sample;
    logic        mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [23:0] mem_wdata;

    assign out_free = !r_out_valid || !i_out_stall;

    // device id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= DEVICE_ID_RST;
        end else if (i_cfg_we) begin
            r_device_id <= i_cfg_wdata;
        end
    end

    ipf_ctrl #(
        .BANK_DEPTH(BANK_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_device_id   (r_device_id),
        .i_out_free    (out_free),
        .o_in_stall    (o_in_stall),
        .o_ctl         (ctl),
        .o_live_sample (live_sample),
        .o_mem_we      (mem_we),
        .o_mem_re      (mem_re),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata)
    );

    ipf_bank_ram #(
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // formatter source: stored entry on dump, held sample otherwise
    assign fmt_sample = ctl.from_mem ? mem_rdata : live_sample;

    ipf_fmt u_fmt (
        .i_sample (fmt_sample),
        .i_ctl    (ctl),
        .o_req    (fmt_req)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_out <= fmt_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

>>> design/ipf_bank_ram.sv
// ----------------------------------------------------------------------------
// ipf_bank_ram
// Single-port sample store for both ping-pong banks, registered read.
// ----------------------------------------------------------------------------
module ipf_bank_ram #(
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [23:0]       i_wdata,
    output logic [23:0]       o_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [23:0] r_mem [0:DEPTH-1];
    logic [23:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read port, data held until next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/ipf_fmt.sv
// ----------------------------------------------------------------------------
// ipf_fmt
// Shared record formatter: tags a stored or live sample, or builds a status.
// ----------------------------------------------------------------------------
module ipf_fmt (
    input  logic             [23:0] i_sample,
    input  ipf_pkg::t_out_ctl       i_ctl,
    output ipf_pkg::t_out_req       o_req
);
    import ipf_pkg::*;

    // status replies carry zero codes
    always_comb begin
        o_req.kind   = i_ctl.kind;
        o_req.status = i_ctl.status;
        o_req.last   = i_ctl.last;
        if (i_ctl.kind == KIND_RECORD) begin
            o_req.i_code = tag_code(i_sample[23:12], TAG_I);
            o_req.q_code = tag_code(i_sample[11:0], TAG_Q);
        end else begin
            o_req.i_code = 16'h0000;
            o_req.q_code = 16'h0000;
        end
    end
endmodule

>>> design/ipf_ctrl.sv
// ----------------------------------------------------------------------------
// ipf_ctrl
// Sequencer: decodes requests, fills the banks, walks a bank on readout.
// ----------------------------------------------------------------------------
`include "iq_sample_pingpong_framer_top_macros.svh"

module ipf_ctrl #(
    parameter int BANK_DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  ipf_pkg::t_in_req                      i_in_data,
    input  logic [7:0]                            i_device_id,
    input  logic                                  i_out_free,
    output logic                                  o_in_stall,
    output ipf_pkg::t_out_ctl                     o_ctl,
    output logic [23:0]                           o_live_sample,
    output logic                                  o_mem_we,
    output logic                                  o_mem_re,
    output logic [$clog2(BANK_DEPTH):0]           o_mem_addr,
    output logic [23:0]                           o_mem_wdata
);
    import ipf_pkg::*;

    localparam int IDX_W = $clog2(BANK_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BANK_DEPTH - 1);

    t_state r_state, n_state;
    t_in_req r_item;
    logic r_started, r_cont, r_fill2, r_rdy1, r_rdy2, r_stat, r_dump_bank;
    logic [IDX_W-1:0] r_widx, r_ridx;

    logic in_acc, is_tick, store_ok, widx_last, ridx_last;
    logic is_query, is_qmode, is_cmode;

    // decode of the held request
    assign in_acc    = i_in_valid && !o_in_stall;
    assign is_tick   = (r_item.op == OP_TICK);
    assign store_ok  = r_started && !r_cont &&
                       ((!r_rdy1 && !r_fill2) || (!r_rdy2 && r_fill2));
    assign widx_last = (r_widx == IDX_LAST);
    assign ridx_last = (r_ridx == IDX_LAST);
    assign is_query  = (r_item.rx_byte == i_device_id);
    assign is_qmode  = (r_item.rx_byte == 8'(i_device_id + CMD_QUERY));
    assign is_cmode  = (r_item.rx_byte == 8'(i_device_id + CMD_CONT));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (is_tick) begin
                    n_state = (r_started && r_cont) ? ST_SEND_REC : ST_IDLE;
                end else begin
                    n_state = is_query ? ST_SEND_STAT : ST_IDLE;
                end
            end
            ST_SEND_REC: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            ST_SEND_STAT: begin
                if (i_out_free) n_state = r_stat ? ST_DUMP : ST_IDLE;
            end
            ST_DUMP: begin
                if (i_out_free && ridx_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall   = 1'b1;
        o_ctl        = '0;
        o_mem_we     = 1'b0;
        o_mem_re     = 1'b0;
        o_mem_addr   = {r_fill2, r_widx};
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_DECODE: begin
                o_mem_we = is_tick && store_ok;
            end
            ST_SEND_REC: begin
                o_ctl.load = i_out_free;
                o_ctl.kind = KIND_RECORD;
                o_ctl.last = 1'b1;
            end
            ST_SEND_STAT: begin
                o_ctl.load   = i_out_free;
                o_ctl.kind   = KIND_STATUS;
                o_ctl.status = r_stat;
                o_ctl.last   = !r_stat;
                // prefetch the first entry of the bank
                o_mem_re     = i_out_free && r_stat;
                o_mem_addr   = {r_dump_bank, {IDX_W{1'b0}}};
            end
            ST_DUMP: begin
                o_ctl.load     = i_out_free;
                o_ctl.kind     = KIND_RECORD;
                o_ctl.last     = ridx_last;
                o_ctl.from_mem = 1'b1;
                o_mem_re       = i_out_free && !ridx_last;
                o_mem_addr     = {r_dump_bank, IDX_W'(r_ridx + 1'b1)};
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_mem_wdata   = {r_item.i_sample, r_item.q_sample};
    assign o_live_sample = {r_item.i_sample, r_item.q_sample};

    // held request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_cont      <= 1'b0;
            r_fill2     <= 1'b0;
            r_rdy1      <= 1'b0;
            r_rdy2      <= 1'b0;
            r_stat      <= 1'b0;
            r_dump_bank <= 1'b0;
            r_widx      <= '0;
            r_ridx      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DECODE) begin
                if (is_tick) begin
                    // bank fill; full bank flips to the other one
                    if (store_ok) begin
                        if (widx_last) begin
                            r_widx  <= '0;
                            r_fill2 <= !r_fill2;
                            if (r_fill2) r_rdy2 <= 1'b1;
                            else         r_rdy1 <= 1'b1;
                        end else begin
                            r_widx <= r_widx + 1'b1;
                        end
                    end
                end else begin
                    r_started <= 1'b1;
                    if (is_query) begin
                        r_stat      <= r_rdy1 || r_rdy2;
                        r_dump_bank <= !r_rdy1;
                        if (r_rdy1)      r_rdy1 <= 1'b0;
                        else if (r_rdy2) r_rdy2 <= 1'b0;
                    end else if (is_qmode) begin
                        r_cont <= 1'b0;
                    end else if (is_cmode) begin
                        r_cont <= 1'b1;
                    end
                end
            end
            // readout walk
            if (r_state == ST_SEND_STAT && i_out_free) begin
                r_ridx <= '0;
            end else if (r_state == ST_DUMP && i_out_free && !ridx_last) begin
                r_ridx <= r_ridx + 1'b1;
            end
        end
    end

    // checks
    `IPF_ASSERT(a_one_port, !(o_mem_we && o_mem_re))
    `IPF_ASSERT(a_accept_decodes, in_acc |=> (r_state == ST_DECODE))
    `IPF_ASSERT(a_no_write_ready, o_mem_we |-> !(r_fill2 ? r_rdy2 : r_rdy1))
    `IPF_ASSERT(a_dump_bank_free, (r_state == ST_DUMP) |-> !(r_dump_bank ? r_rdy2 : r_rdy1))
    `IPF_ASSERT(a_load_when_free, o_ctl.load |-> i_out_free)
endmodule
